// ===== hdl/pfs_pkg.sv =====
package pfs_pkg;

  localparam int unsigned PcW = 3;

  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PC_PASS     = 3'd0;
  localparam pc_t PC_CHECK    = 3'd1;
  localparam pc_t PC_DIV_INIT = 3'd2;
  localparam pc_t PC_DIV_STEP = 3'd3;
  localparam pc_t PC_FINISH   = 3'd4;

  localparam logic [31:0] PERIOD_MAX = 32'h0000_FFFF;
  // multiplicative inverses mod 2^32, exact quotient when the factor divides
  localparam logic [31:0] INV5 = 32'hCCCC_CCCD;
  localparam logic [31:0] INV3 = 32'hAAAA_AAAB;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PASS,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_PASS,
    C_SMALL,
    C_CNT_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic even;
    logic div5;
    logic div3;
  } factor_flags_t;

  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t w;
    case (pc)
      PC_PASS:     w = '{op: OP_PASS,     cond: C_PASS,     target: PC_PASS};
      PC_CHECK:    w = '{op: OP_NONE,     cond: C_SMALL,    target: PC_FINISH};
      PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_ALWAYS,   target: PC_DIV_STEP};
      PC_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_CNT_MORE, target: PC_DIV_STEP};
      PC_FINISH:   w = '{op: OP_FINISH,   cond: C_OUT_BUSY, target: PC_FINISH};
      default:     w = '{op: OP_FINISH,   cond: C_OUT_BUSY, target: PC_FINISH};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/pfs_residue.sv =====
module pfs_residue import pfs_pkg::*; (
  input  logic [31:0]   value_i,
  output factor_flags_t flags_o
);

  logic [6:0] nib_sum;
  logic [4:0] fold;
  logic [3:0] res15;

  // 16 = 1 mod 15, so the nibble sum keeps the residue mod 15
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < 8; i++) begin
      nib_sum = nib_sum + {3'b000, value_i[4*i +: 4]};
    end
    fold  = {2'b00, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
    res15 = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];
  end

  assign flags_o.even = ~value_i[0];
  assign flags_o.div5 = (res15 == 4'd0) || (res15 == 4'd5) || (res15 == 4'd10);
  assign flags_o.div3 = (res15 == 4'd0) || (res15 == 4'd3) || (res15 == 4'd6) ||
                        (res15 == 4'd9) || (res15 == 4'd12);

endmodule

// ===== hdl/prescaler_factor_split_unit.sv =====
// sequence: at most 16 factor passes strip factors 2, 5 and 3; if the period is
//   still above PERIOD_MAX, the fallback division runs (32 restoring steps)
// throughput: one request at a time, next request taken the cycle after
//   the result is registered; the pass loop, divider and a held result set it
// reset: asynchronous active-low, clears sequencer, busy and output valid
module prescaler_factor_split_unit import pfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] divider_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] prescale_factor_o,
  output logic [15:0] period_factor_o
);

  logic          busy_q, busy_d;
  pc_t           pc_q, pc_d;
  logic          out_valid_q, out_valid_d;
  logic [4:0]    cnt_q, cnt_d;

  logic [31:0]   div_q, div_d;
  logic [15:0]   p_q, p_d;
  logic [31:0]   q_q, q_d;
  logic [16:0]   dvs_q, dvs_d;
  logic [16:0]   rem_q, rem_d;
  logic [15:0]   pre_q, pre_d;
  logic [15:0]   per_q, per_d;

  ctrl_word_t    cw;
  factor_flags_t flags;
  logic          big, pass_ok, taken, in_req;
  logic [31:0]   inv, prod;
  logic [17:0]   rem_sh, rem_diff;
  logic          ge;

  pfs_residue u_residue (
    .value_i (q_q),
    .flags_o (flags)
  );

  assign in_req  = in_valid_i && !busy_q;
  assign cw      = ucode_rom(pc_q);
  assign big     = q_q > PERIOD_MAX;
  assign pass_ok = big && (flags.even || flags.div5 || flags.div3);
  assign inv     = flags.div5 ? INV5 : INV3;
  assign prod    = q_q * inv;

  assign rem_sh   = {rem_q, q_q[31]};
  assign ge       = rem_sh >= {1'b0, dvs_q};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_PASS:     taken = pass_ok;
      C_SMALL:    taken = !big;
      C_CNT_MORE: taken = cnt_q != '1;
      C_OUT_BUSY: taken = out_valid_q && out_stall_i;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    cnt_d       = cnt_q;
    div_d       = div_q;
    p_d         = p_q;
    q_d         = q_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    pre_d       = pre_q;
    per_d       = per_q;

    if (!busy_q) begin
      pc_d = PC_PASS;
      if (in_req) begin
        busy_d = 1'b1;
        div_d  = divider_i;
        p_d    = 16'h0001;
        q_d    = divider_i;
      end
    end else begin
      pc_d = taken ? cw.target : pc_t'(pc_q + 1'b1);
      case (cw.op)
        OP_PASS: begin
          if (pass_ok) begin
            if (flags.even) begin
              p_d = {p_q[14:0], 1'b0};
              q_d = {1'b0, q_q[31:1]};
            end else if (flags.div5) begin
              p_d = {p_q[13:0], 2'b00} + p_q;
              q_d = prod;
            end else begin
              p_d = {p_q[14:0], 1'b0} + p_q;
              q_d = prod;
            end
          end
        end
        OP_DIV_INIT: begin
          dvs_d = {1'b0, div_q[31:16]} + 17'd1;
          rem_d = '0;
          q_d   = div_q;
          cnt_d = '0;
        end
        OP_DIV_STEP: begin
          // restoring step, quotient bits shift in behind the dividend
          rem_d = ge ? rem_diff[16:0] : rem_sh[16:0];
          q_d   = {q_q[30:0], ge};
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == '1) begin
            p_d = dvs_q[15:0];
          end
        end
        OP_FINISH: begin
          if (!taken) begin
            pre_d       = p_q;
            per_d       = q_q[15:0];
            out_valid_d = 1'b1;
            busy_d      = 1'b0;
            pc_d        = PC_PASS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PC_PASS;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    p_q   <= p_d;
    q_q   <= q_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    pre_q <= pre_d;
    per_q <= per_d;
  end

  assign in_stall_o        = busy_q;
  assign out_valid_o       = out_valid_q;
  assign prescale_factor_o = pre_q;
  assign period_factor_o   = per_q;

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q) && ($past(pc_q) == PC_FINISH))
    else $error("result raised outside the finish step");

  a_accept_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> busy_q && (pc_q == PC_PASS))
    else $error("request did not start the pass loop");

  a_idle_pc_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == PC_PASS)
    else $error("sequencer not at entry while idle");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (pc_q == PC_DIV_STEP) |-> rem_q < dvs_q)
    else $error("division remainder not below divisor");

endmodule

// ===== verif/prescaler_factor_split_unit_tb.sv =====
`timescale 1ns / 1ps

module prescaler_factor_split_unit_tb import pfs_pkg::*; ();

  localparam int NumRandom = 1900;
  localparam int NumDirected = 19;
  localparam int SettleCycles = 120;

  typedef struct packed {
    logic [15:0] prescale;
    logic [15:0] period;
    logic        fell_back;
  } factors_t;

  typedef struct packed {
    logic [31:0] divider;
    logic        typed;
    logic [15:0] prescale;
    logic [15:0] period;
  } divider_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] divider_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] prescale_factor_o;
  logic [15:0] period_factor_o;

  factors_t expected_factors[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_fallback = 0;
  bit       hold_rx = 1'b0;

  // typed rows carry the answer, the rest go through split_divider
  divider_row_t divider_rows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, 16'd1,     16'd0},
    '{32'h0000_0001, 1'b1, 16'd1,     16'd1},
    '{32'h0000_FFFF, 1'b1, 16'd1,     16'hFFFF},
    '{32'h0001_0000, 1'b1, 16'd2,     16'h8000},
    '{32'h0001_0001, 1'b1, 16'd2,     16'h8000},
    '{32'h0001_FFFF, 1'b1, 16'd2,     16'hFFFF},
    '{32'h8000_0000, 1'b1, 16'd0,     16'h8000},
    '{32'hFFFF_0000, 1'b1, 16'd0,     16'hFFFF},
    '{32'hFFFF_FFFF, 1'b1, 16'd0,     16'hFFFF},
    '{32'd327675,    1'b1, 16'd5,     16'hFFFF},
    '{32'd196599,    1'b1, 16'd3,     16'd65533},
    '{32'h5555_5555, 1'b0, 16'd0,     16'd0},
    '{32'hAAAA_AAAA, 1'b0, 16'd0,     16'd0},
    '{32'd3486784401, 1'b0, 16'd0,    16'd0},
    '{32'd1220703125, 1'b0, 16'd0,    16'd0},
    '{32'hFFFE_FFFF, 1'b0, 16'd0,     16'd0},
    '{32'h7FFF_FFFF, 1'b0, 16'd0,     16'd0},
    '{32'hFFFF_0001, 1'b0, 16'd0,     16'd0},
    '{32'd1000000,   1'b0, 16'd0,     16'd0}
  };

  prescaler_factor_split_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .divider_i        (divider_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .prescale_factor_o(prescale_factor_o),
    .period_factor_o  (period_factor_o)
  );

  function automatic factors_t split_divider(input logic [31:0] divider);
    factors_t    f;
    logic [31:0] per;
    logic [31:0] div_by;
    logic [15:0] pre;
    bit          go;
    per = divider;
    pre = 16'd1;
    go = 1'b1;
    while (go && per > PERIOD_MAX) begin
      if (!per[0]) begin
        pre = pre << 1;
        per = per >> 1;
      end else if (per % 32'd5 == 32'd0) begin
        pre = pre * 16'd5;
        per = per / 32'd5;
      end else if (per % 32'd3 == 32'd0) begin
        pre = pre * 16'd3;
        per = per / 32'd3;
      end else begin
        go = 1'b0;
      end
    end
    f.fell_back = per > PERIOD_MAX;
    if (f.fell_back) begin
      div_by = (divider >> 16) + 32'd1;
      per = divider / div_by;
      pre = div_by[15:0];
    end
    f.prescale = pre;
    f.period = per[15:0];
    return f;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_divider();
    logic [63:0] v;
    int          steps;
    int          pick;
    int          f;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: v = {32'd0, $urandom()};
      5:       v = {32'd0, $urandom_range(0, 32'h3_FFFF)};
      6:       v = {32'd0, $urandom_range(0, 1) ? (32'hFFFF_0000 | $urandom_range(0, 16'hFFFF))
                                                : (32'hFFFF_FFFF - $urandom_range(0, 4096))};
      7:       v = {32'd0, $urandom() << $urandom_range(0, 31)};
      default: begin
        // smooth numbers keep the pass loop running long
        v = ($urandom_range(0, 3) == 0) ? 64'd1 : {32'd0, $urandom_range(1, 4000)};
        steps = $urandom_range(4, 40);
        repeat (steps) begin
          case ($urandom_range(0, 2))
            0:       f = 2;
            1:       f = 3;
            default: f = 5;
          endcase
          if (v * f <= 64'hFFFF_FFFF) v = v * f;
        end
      end
    endcase
    return v[31:0];
  endfunction

  task automatic send_divider(input logic [31:0] divider, input bit typed,
                              input logic [15:0] pre, input logic [15:0] per,
                              input bit calm);
    int       gap;
    factors_t f;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      divider_i <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    divider_i <= divider;
    do @(posedge clk_i); while (in_stall_o);
    f = split_divider(divider);
    if (typed) begin
      f.prescale = pre;
      f.period = per;
    end
    if (f.fell_back) n_fallback++;
    expected_factors.push_back(f);
    n_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // long receiver hold-off while the sender keeps offering requests
  initial begin
    repeat (3000) @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    int stall_left;
    bit calm;
    factors_t want;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_factors.size() == 0) begin
          $display("%0t: unexpected result prescale %h period %h", $time,
                   prescale_factor_o, period_factor_o);
          n_errors++;
        end else begin
          want = expected_factors.pop_front();
          n_checked++;
          if (prescale_factor_o !== want.prescale) begin
            $display("%0t: prescale_factor expected %h actual %h", $time,
                     want.prescale, prescale_factor_o);
            n_errors++;
          end
          if (period_factor_o !== want.period) begin
            $display("%0t: period_factor expected %h actual %h", $time,
                     want.period, period_factor_o);
            n_errors++;
          end
        end
      end
      calm = n_checked >= 1200 && n_checked < 1400;
      if (hold_rx) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = calm ? 0 : idle_len();
      end
    end
  end

  initial begin
    int wait_cycles;
    in_valid_i = 1'b0;
    divider_i = '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (divider_rows[i]) begin
      send_divider(divider_rows[i].divider, divider_rows[i].typed,
                   divider_rows[i].prescale, divider_rows[i].period, 1'b0);
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_divider(random_divider(), 1'b0, 16'd0, 16'd0, i >= 700 && i < 900);
    end
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_factors.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_factors.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_factors.size());
      n_errors++;
    end
    $display("tb: %0d dividers split (%0d from the directed table), %0d results checked",
             n_sent, NumDirected, n_checked);
    $display("tb: %0d needed the fallback divide, %0d mismatches", n_fallback, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pfs_pkg.sv
hdl/pfs_residue.sv
hdl/prescaler_factor_split_unit.sv
verif/prescaler_factor_split_unit_tb.sv
